/* src/hrl_pkg.sv */
// Shared types, codes and constants of the hex record loader.
package hrl_pkg;

   localparam int OUT_CAP = 18;
   localparam int CNT_W = $clog2(OUT_CAP + 1);
   localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'hA0;

   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_START = 3'd1,
      ACT_SEND  = 3'd2,
      ACT_STOP  = 3'd3,
      ACT_WAIT  = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_NONE     = 3'd0,
      ST_WRITTEN  = 3'd1,
      ST_END      = 3'd2,
      ST_CHECKSUM = 3'd3,
      ST_TOO_LONG = 3'd4
   } rsp_status_type;

   typedef enum logic [1:0] {
      EV_NONE,
      EV_FINISH,
      EV_WRITE
   } event_type;

   typedef enum logic [1:0] {
      BYTE_ZERO,
      BYTE_DEVICE,
      BYTE_POINTER,
      BYTE_DATA
   } byte_sel_type;

   typedef struct packed {
      logic           take_char;
      logic           clear_idx;
      logic           open_session;
      logic           readdress;
      logic           send_data;
      logic           close_session;
      logic           emit;
      logic           emit_last;
      action_type     emit_action;
      byte_sel_type   emit_byte;
      rsp_status_type emit_status;
   } dp_cmd_type;

   typedef struct packed {
      event_type      ev_kind;
      rsp_status_type ev_status;
      logic           session_open;
      logic           page_full;
      logic           data_done;
      logic           out_free;
   } dp_stat_type;

endpackage

/* src/hrl_channels.sv */
// Request, response and register-write channel interfaces.
interface hrl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;

   modport source (output valid, output character, input ready);
   modport sink (input valid, input character, output ready);
endinterface

interface hrl_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] bus_action;
   logic [7:0] bus_byte;
   logic [2:0] status;
   logic       last;

   modport source (output valid, output bus_action, output bus_byte, output status,
                   output last, input ready);
   modport sink (input valid, input bus_action, input bus_byte, input status,
                 input last, output ready);
endinterface

interface hrl_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] device_address;

   modport source (output valid, output device_address, input ready);
   modport sink (input valid, input device_address, output ready);
endinterface

/* src/hrl_datapath.sv */
// Record parser, data buffer, write pointer tracking and response register.
module hrl_datapath import hrl_pkg::*; #(
   parameter int MAX_DATA = 8,
   parameter int PAGE_SIZE = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] character,
   input  dp_cmd_type cmd,
   output dp_stat_type stat,
   hrl_rsp_if.source  rsp_chan,
   hrl_csr_if.sink    csr_chan
);

   localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
   localparam int PW = $clog2(PAGE_SIZE + 1);
   localparam logic [7:0] COLON = 8'h3A;
   localparam logic [7:0] POS_LENGTH = 8'd0;
   localparam logic [7:0] POS_ADDR_LO = 8'd2;
   localparam logic [7:0] POS_KIND = 8'd3;

   typedef enum logic [1:0] {
      PH_WAIT,
      PH_HEAD,
      PH_DATA,
      PH_SUM
   } phase_type;

   function automatic logic [256*PW-1:0] build_mod_table();
      logic [256*PW-1:0] t;
      t = '0;
      for (int i = 0; i < 256; i++) begin
         t[i*PW +: PW] = PW'(i % PAGE_SIZE);
      end
      return t;
   endfunction

   localparam logic [256*PW-1:0] MOD_TABLE = build_mod_table();

   function automatic logic [PW-1:0] page_pos(input logic [7:0] a);
      return MOD_TABLE[int'(a) * PW +: PW];
   endfunction

   phase_type      phase_ff;
   logic [3:0]     hi_ff;
   logic           pend_ff;
   logic [7:0]     fpos_ff;
   logic [7:0]     len_ff;
   logic [7:0]     addr_ff;
   logic [7:0]     sum_ff;
   logic           open_ff;
   logic [PW-1:0]  po_ff;
   logic [7:0]     wp_ff;
   logic [7:0]     idx_ff;
   logic [7:0]     dev_ff;
   logic [7:0]     rdata_ff;
   logic [7:0]     mem [MAX_DATA];
   logic           rsp_valid_ff;
   action_type     act_ff;
   logic [7:0]     byte_ff;
   rsp_status_type status_ff;
   logic           last_ff;

   logic           is_colon;
   logic           hex_ok;
   logic [3:0]     hex_val;
   logic [7:0]     byte_val;
   logic [7:0]     sum_next;
   logic [7:0]     fpos_inc;
   logic           byte_ready;
   logic           mem_we;
   event_type      ev_kind;
   rsp_status_type ev_status;
   logic [7:0]     byte_in;

   always_comb begin
      hex_ok = 1'b1;
      hex_val = 4'd0;
      if (character inside {[8'h30:8'h39]}) begin
         hex_val = 4'(character - 8'h30);
      end else if (character inside {[8'h41:8'h46]}) begin
         hex_val = 4'(character - 8'h37);
      end else if (character inside {[8'h61:8'h66]}) begin
         hex_val = 4'(character - 8'h57);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign is_colon = (character == COLON);
   assign byte_val = {hi_ff, hex_val};
   assign sum_next = sum_ff + byte_val;
   assign fpos_inc = fpos_ff + 8'd1;
   assign byte_ready = !is_colon && (phase_ff != PH_WAIT) && hex_ok && pend_ff;
   assign mem_we = cmd.take_char && byte_ready && (phase_ff == PH_DATA)
                   && (fpos_ff < 8'(MAX_DATA));

   always_comb begin
      ev_kind = EV_NONE;
      ev_status = ST_NONE;
      if (byte_ready) begin
         case (phase_ff)
            PH_HEAD: begin
               if (fpos_ff == POS_KIND) begin
                  if (byte_val != 8'd0) begin
                     ev_kind = EV_FINISH;
                     ev_status = ST_END;
                  end else if (len_ff > 8'(MAX_DATA)) begin
                     ev_kind = EV_FINISH;
                     ev_status = ST_TOO_LONG;
                  end
               end
            end
            PH_SUM: begin
               if (sum_next != 8'd0) begin
                  ev_kind = EV_FINISH;
                  ev_status = ST_CHECKSUM;
               end else begin
                  ev_kind = EV_WRITE;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         hi_ff <= 4'd0;
         pend_ff <= 1'b0;
         fpos_ff <= 8'd0;
         len_ff <= 8'd0;
         addr_ff <= 8'd0;
         sum_ff <= 8'd0;
         open_ff <= 1'b0;
         po_ff <= '0;
         wp_ff <= 8'd0;
         idx_ff <= 8'd0;
         dev_ff <= DEVICE_ADDRESS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            dev_ff <= csr_chan.device_address;
         end
         if (cmd.take_char) begin
            if (is_colon) begin
               phase_ff <= PH_HEAD;
               fpos_ff <= 8'd0;
               pend_ff <= 1'b0;
               hi_ff <= 4'd0;
               sum_ff <= 8'd0;
            end else if (phase_ff != PH_WAIT && hex_ok) begin
               if (!pend_ff) begin
                  hi_ff <= hex_val;
                  pend_ff <= 1'b1;
               end else begin
                  pend_ff <= 1'b0;
                  sum_ff <= sum_next;
                  case (phase_ff)
                     PH_HEAD: begin
                        if (fpos_ff == POS_LENGTH) begin
                           len_ff <= byte_val;
                        end
                        if (fpos_ff == POS_ADDR_LO) begin
                           addr_ff <= byte_val;
                        end
                        if (fpos_ff == POS_KIND) begin
                           fpos_ff <= 8'd0;
                           if (ev_kind != EV_NONE) begin
                              phase_ff <= PH_WAIT;
                           end else if (len_ff == 8'd0) begin
                              phase_ff <= PH_SUM;
                           end else begin
                              phase_ff <= PH_DATA;
                           end
                        end else begin
                           fpos_ff <= fpos_inc;
                        end
                     end
                     PH_DATA: begin
                        if (fpos_inc >= len_ff) begin
                           fpos_ff <= 8'd0;
                           phase_ff <= PH_SUM;
                        end else begin
                           fpos_ff <= fpos_inc;
                        end
                     end
                     default: begin
                        phase_ff <= PH_WAIT;
                     end
                  endcase
               end
            end
         end
         if (cmd.clear_idx) begin
            idx_ff <= 8'd0;
         end
         if (cmd.open_session) begin
            wp_ff <= addr_ff;
            po_ff <= page_pos(addr_ff);
            open_ff <= 1'b1;
         end
         if (cmd.readdress) begin
            po_ff <= page_pos(wp_ff);
         end
         if (cmd.send_data) begin
            wp_ff <= wp_ff + 8'd1;
            po_ff <= po_ff + PW'(1);
            idx_ff <= idx_ff + 8'd1;
         end
         if (cmd.close_session) begin
            open_ff <= 1'b0;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[fpos_ff[AW-1:0]] <= byte_val;
      end
      rdata_ff <= mem[idx_ff[AW-1:0]];
   end

   always_comb begin
      case (cmd.emit_byte)
         BYTE_DEVICE:  byte_in = dev_ff;
         BYTE_POINTER: byte_in = wp_ff;
         BYTE_DATA:    byte_in = rdata_ff;
         default:      byte_in = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         act_ff <= cmd.emit_action;
         byte_ff <= byte_in;
         status_ff <= cmd.emit_status;
         last_ff <= cmd.emit_last;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.bus_action = act_ff;
   assign rsp_chan.bus_byte = byte_ff;
   assign rsp_chan.status = status_ff;
   assign rsp_chan.last = last_ff;
   assign csr_chan.ready = !reset;

   assign stat.ev_kind = ev_kind;
   assign stat.ev_status = ev_status;
   assign stat.session_open = open_ff;
   assign stat.page_full = (po_ff >= PW'(PAGE_SIZE));
   assign stat.data_done = (idx_ff >= len_ff);
   assign stat.out_free = !rsp_valid_ff || rsp_chan.ready;

endmodule

/* src/hrl_controller.sv */
// Sequencer for bus actions and status responses of each record.
module hrl_controller import hrl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIN_STOP,
      S_FIN_STATUS,
      S_OPEN_START,
      S_OPEN_DEV,
      S_OPEN_ADDR,
      S_DATA_CHK,
      S_PG_STOP,
      S_PG_WAIT,
      S_PG_START,
      S_PG_DEV,
      S_PG_ADDR,
      S_DATA_SEND,
      S_WR_STATUS
   } state_type;

   state_type      state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   rsp_status_type code_ff, code_in;
   logic           go;
   logic           room;
   logic           emitting;
   logic           final_item;

   assign room = (cnt_ff < CNT_W'(OUT_CAP));
   assign go = stat.out_free || !room;
   assign req_ready = (state_ff == S_IDLE) && !reset;

   always_comb begin
      cmd = '0;
      cmd.emit_action = ACT_NONE;
      cmd.emit_byte = BYTE_ZERO;
      cmd.emit_status = ST_NONE;
      state_in = state_ff;
      cnt_in = cnt_ff;
      code_in = code_ff;
      emitting = 1'b0;
      final_item = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_char = 1'b1;
               cnt_in = '0;
               case (stat.ev_kind)
                  EV_FINISH: begin
                     code_in = stat.ev_status;
                     state_in = stat.session_open ? S_FIN_STOP : S_FIN_STATUS;
                  end
                  EV_WRITE: begin
                     cmd.clear_idx = 1'b1;
                     state_in = stat.session_open ? S_DATA_CHK : S_OPEN_START;
                  end
                  default: ;
               endcase
            end
         end
         S_FIN_STOP: begin
            emitting = 1'b1;
            cmd.emit_action = ACT_STOP;
            if (go) begin
               cmd.close_session = 1'b1;
               state_in = S_FIN_STATUS;
            end
         end
         S_FIN_STATUS: begin
            emitting = 1'b1;
            final_item = 1'b1;
            cmd.emit_status = code_ff;
            if (go) begin
               cmd.close_session = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_OPEN_START: begin
            emitting = 1'b1;
            cmd.emit_action = ACT_START;
            if (go) begin
               cmd.open_session = 1'b1;
               state_in = S_OPEN_DEV;
            end
         end
         S_OPEN_DEV: begin
            emitting = 1'b1;
            cmd.emit_action = ACT_SEND;
            cmd.emit_byte = BYTE_DEVICE;
            if (go) begin
               state_in = S_OPEN_ADDR;
            end
         end
         S_OPEN_ADDR: begin
            emitting = 1'b1;
            cmd.emit_action = ACT_SEND;
            cmd.emit_byte = BYTE_POINTER;
            if (go) begin
               state_in = S_DATA_CHK;
            end
         end
         S_DATA_CHK: begin
            if (stat.data_done) begin
               state_in = S_WR_STATUS;
            end else if (stat.page_full) begin
               state_in = S_PG_STOP;
            end else begin
               state_in = S_DATA_SEND;
            end
         end
         S_PG_STOP: begin
            emitting = 1'b1;
            cmd.emit_action = ACT_STOP;
            if (go) begin
               state_in = S_PG_WAIT;
            end
         end
         S_PG_WAIT: begin
            emitting = 1'b1;
            cmd.emit_action = ACT_WAIT;
            if (go) begin
               state_in = S_PG_START;
            end
         end
         S_PG_START: begin
            emitting = 1'b1;
            cmd.emit_action = ACT_START;
            if (go) begin
               state_in = S_PG_DEV;
            end
         end
         S_PG_DEV: begin
            emitting = 1'b1;
            cmd.emit_action = ACT_SEND;
            cmd.emit_byte = BYTE_DEVICE;
            if (go) begin
               state_in = S_PG_ADDR;
            end
         end
         S_PG_ADDR: begin
            emitting = 1'b1;
            cmd.emit_action = ACT_SEND;
            cmd.emit_byte = BYTE_POINTER;
            if (go) begin
               cmd.readdress = 1'b1;
               state_in = S_DATA_CHK;
            end
         end
         S_DATA_SEND: begin
            emitting = 1'b1;
            cmd.emit_action = ACT_SEND;
            cmd.emit_byte = BYTE_DATA;
            if (go) begin
               cmd.send_data = 1'b1;
               state_in = S_DATA_CHK;
            end
         end
         S_WR_STATUS: begin
            emitting = 1'b1;
            final_item = 1'b1;
            cmd.emit_status = ST_WRITTEN;
            if (go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      cmd.emit = emitting && go && room;
      cmd.emit_last = final_item || (cnt_ff == CNT_W'(OUT_CAP - 1));
      if (emitting && go && room) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         code_ff <= ST_NONE;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         code_ff <= code_in;
      end
   end

endmodule

/* src/hex_record_loader_page_writer_unit.sv */
// Top level of the hex record loader and paged memory writer.
//
//   channel    dir  handshake     payload
//   req_chan   in   valid/ready   character[7:0]
//   rsp_chan   out  valid/ready   bus_action[2:0] bus_byte[7:0] status[2:0] last
//   csr_chan   in   valid/ready   device_address[7:0] (ready out of reset)
//
// Characters that end no record may follow back to back. A good closing character opens a
// write if none is open (start, device, pointer), sends the data with stop, wait, start,
// device and pointer at each page break, then a written status; an end, overlong or checksum
// record gives a stop if a write is open, then its status. The sequencer emits at most one
// result a cycle into one output register, dropping any past OUT_CAP a record; a stalled
// response holds it; no request is taken meanwhile. Synchronous reset needs no clearing pass.
module hex_record_loader_page_writer_unit import hrl_pkg::*; #(
   parameter int MAX_DATA = 8,
   parameter int PAGE_SIZE = 16
) (
   input  logic      clock,
   input  logic      reset,
   hrl_req_if.sink   req_chan,
   hrl_rsp_if.source rsp_chan,
   hrl_csr_if.sink   csr_chan
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        req_ready;

   hrl_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   hrl_datapath #(
      .MAX_DATA  (MAX_DATA),
      .PAGE_SIZE (PAGE_SIZE)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .character (req_chan.character),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_chan  (rsp_chan),
      .csr_chan  (csr_chan)
   );

   assign req_chan.ready = req_ready;

   a_status_final: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status != ST_NONE
      |-> rsp_chan.last && rsp_chan.bus_action == ACT_NONE)
      else $error("status response is not a final plain response");

   a_data_in_session: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && cmd.emit_byte == BYTE_DATA |-> stat.session_open)
      else $error("data byte sent without an open write");

   a_quiet_char: assert property (@(posedge clock) disable iff (reset)
      cmd.take_char && stat.ev_kind == EV_NONE |=> req_chan.ready)
      else $error("request without results left the block busy");

endmodule

/* bench/hrl_checker.sv */
`timescale 1ns / 1ps
// Bus-action predictor and response checker for the hex record loader.
module hrl_checker import hrl_pkg::*; #(
   parameter int MAX_DATA = 8,
   parameter int PAGE_SIZE = 16
) (
   input  logic clock,
   input  logic reset,
   hrl_req_if   req,
   hrl_rsp_if   rsp,
   hrl_csr_if   csr,
   output int   error_count,
   output int   pending_results,
   output int   results_seen
);

   localparam logic [7:0] COLON = 8'h3A;

   typedef enum logic [1:0] {
      SEEK_COLON,
      IN_HEADER,
      IN_DATA,
      IN_CHECKSUM
   } parse_phase_type;

   typedef struct {
      action_type     act;
      logic [7:0]     data;
      rsp_status_type st;
      logic           last;
   } bus_step_type;

   bus_step_type    expected_steps[$];
   bus_step_type    batch[$];
   parse_phase_type phase;
   logic [7:0]   dev_addr;
   logic [3:0]   hi_nibble;
   logic         nibble_held;
   logic [7:0]   field_pos;
   logic [7:0]   rec_len;
   logic [15:0]  rec_addr;
   logic [7:0]   rec_kind;
   logic [7:0]   rec_sum;
   logic [7:0]   rec_data[MAX_DATA];
   logic         writing;
   int           page_fill;
   logic [7:0]   wr_ptr;
   int           errors = 0;
   int           results = 0;

   task automatic clear_state();
      expected_steps.delete();
      phase = SEEK_COLON;
      dev_addr = DEVICE_ADDRESS_RESET;
      hi_nibble = 4'd0;
      nibble_held = 1'b0;
      field_pos = 8'd0;
      rec_len = 8'd0;
      rec_addr = 16'd0;
      rec_kind = 8'd0;
      rec_sum = 8'd0;
      foreach (rec_data[i]) rec_data[i] = 8'd0;
      writing = 1'b0;
      page_fill = 0;
      wr_ptr = 8'd0;
   endtask

   task automatic emit(input action_type a, input logic [7:0] b, input rsp_status_type s);
      bus_step_type step;
      step.act = a;
      step.data = b;
      step.st = s;
      step.last = 1'b0;
      if (batch.size() < OUT_CAP) batch.push_back(step);
   endtask

   task automatic close_session(input rsp_status_type s);
      if (writing) emit(ACT_STOP, 8'h00, ST_NONE);
      writing = 1'b0;
      emit(ACT_NONE, 8'h00, s);
      phase = SEEK_COLON;
   endtask

   task automatic address_device();
      emit(ACT_START, 8'h00, ST_NONE);
      emit(ACT_SEND, dev_addr, ST_NONE);
      emit(ACT_SEND, wr_ptr, ST_NONE);
      page_fill = int'(wr_ptr) % PAGE_SIZE;
   endtask

   task automatic write_record();
      int i;
      if (!writing) begin
         wr_ptr = rec_addr[7:0];
         address_device();
         writing = 1'b1;
      end
      for (i = 0; i < int'(rec_len) && i < MAX_DATA; i++) begin
         if (page_fill >= PAGE_SIZE) begin
            emit(ACT_STOP, 8'h00, ST_NONE);
            emit(ACT_WAIT, 8'h00, ST_NONE);
            address_device();
         end
         emit(ACT_SEND, rec_data[i], ST_NONE);
         wr_ptr = wr_ptr + 8'd1;
         page_fill++;
      end
      emit(ACT_NONE, 8'h00, ST_WRITTEN);
      phase = SEEK_COLON;
   endtask

   task automatic take_byte(input logic [7:0] b);
      rec_sum = rec_sum + b;
      case (phase)
         IN_HEADER: begin
            case (field_pos)
               8'd0: rec_len = b;
               8'd1: rec_addr[15:8] = b;
               8'd2: rec_addr[7:0] = b;
               default: rec_kind = b;
            endcase
            field_pos = field_pos + 8'd1;
            if (field_pos == 8'd4) begin
               field_pos = 8'd0;
               if (rec_kind != 8'd0) close_session(ST_END);
               else if (int'(rec_len) > MAX_DATA) close_session(ST_TOO_LONG);
               else if (rec_len == 8'd0) phase = IN_CHECKSUM;
               else phase = IN_DATA;
            end
         end
         IN_DATA: begin
            if (int'(field_pos) < MAX_DATA) rec_data[field_pos] = b;
            field_pos = field_pos + 8'd1;
            if (field_pos >= rec_len) begin
               field_pos = 8'd0;
               phase = IN_CHECKSUM;
            end
         end
         default: begin
            if (rec_sum != 8'd0) close_session(ST_CHECKSUM);
            else write_record();
         end
      endcase
   endtask

   function automatic int hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      return -1;
   endfunction

   task automatic decode_character(input logic [7:0] c);
      int v;
      batch.delete();
      if (c == COLON) begin
         phase = IN_HEADER;
         field_pos = 8'd0;
         nibble_held = 1'b0;
         hi_nibble = 4'd0;
         rec_sum = 8'd0;
         return;
      end
      if (phase == SEEK_COLON) return;
      v = hex_value(c);
      if (v < 0) return;
      if (!nibble_held) begin
         hi_nibble = v[3:0];
         nibble_held = 1'b1;
         return;
      end
      nibble_held = 1'b0;
      take_byte({hi_nibble, v[3:0]});
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) expected_steps.push_back(batch[i]);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         errors++;
         $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      bus_step_type want;
      if (reset) begin
         clear_state();
      end else begin
         if (rsp.valid && rsp.ready) begin
            results++;
            if (expected_steps.size() == 0) begin
               errors++;
               $display("%0t unexpected result: expected none, actual action %0d byte %0h %s%0d",
                        $time, rsp.bus_action, rsp.bus_byte, "status ", rsp.status);
            end else begin
               want = expected_steps.pop_front();
               check_field("bus_action", 8'(rsp.bus_action), 8'(want.act));
               check_field("bus_byte", rsp.bus_byte, want.data);
               check_field("status", 8'(rsp.status), 8'(want.st));
               check_field("last", 8'(rsp.last), 8'(want.last));
            end
         end
         if (csr.valid && csr.ready) dev_addr = csr.device_address;
         if (req.valid && req.ready) decode_character(req.character);
      end
      error_count <= errors;
      pending_results <= expected_steps.size();
      results_seen <= results;
   end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Top of the hex record loader bench: clock, reset, record stimulus and verdict.
module tb;

   localparam int MAX_DATA = 8;
   localparam int PAGE_SIZE = 16;
   localparam int TOTAL_CHARS = 230;
   localparam logic [7:0] COLON = 8'h3A;

   logic clock;
   logic reset;
   bit   calm = 1'b0;
   int   noise_pct = 15;
   int   chars_sent = 0;
   int   record_chars = 0;
   int   records_sent = 0;
   int   error_count;
   int   pending_results;
   int   results_seen;

   hrl_req_if req_chan();
   hrl_rsp_if rsp_chan();
   hrl_csr_if csr_chan();

   hex_record_loader_page_writer_unit #(
      .MAX_DATA(MAX_DATA),
      .PAGE_SIZE(PAGE_SIZE)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   hrl_checker #(
      .MAX_DATA(MAX_DATA),
      .PAGE_SIZE(PAGE_SIZE)
   ) watch (
      .clock(clock),
      .reset(reset),
      .req(req_chan),
      .rsp(rsp_chan),
      .csr(csr_chan),
      .error_count(error_count),
      .pending_results(pending_results),
      .results_seen(results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= calm || ($urandom_range(99) >= 35);
      end
   end

   initial begin
      #3_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
   endfunction

   function automatic bit is_hex(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
   endfunction

   function automatic logic [7:0] junk_char(input bit hex_allowed);
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (c == COLON || (!hex_allowed && is_hex(c)));
      return c;
   endfunction

   task automatic send_char(input logic [7:0] c);
      while (!calm && $urandom_range(99) < 35) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.character <= c;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_hex(input logic [7:0] b, input bit lower);
      send_char(hex_char(b[7:4], lower));
      if ($urandom_range(99) < noise_pct) send_char(junk_char(1'b0));
      send_char(hex_char(b[3:0], lower));
      if ($urandom_range(99) < noise_pct) send_char(junk_char(1'b0));
      record_chars += 2;
   endtask

   task automatic send_record(input logic [7:0] count, input logic [15:0] addr,
                              input logic [7:0] kind, input bit bad_sum, input int cut);
      logic [7:0] body[$];
      logic [7:0] sum;
      bit         lower;
      int         n_data;
      body.push_back(count);
      body.push_back(addr[15:8]);
      body.push_back(addr[7:0]);
      body.push_back(kind);
      n_data = (int'(count) > MAX_DATA) ? 2 : int'(count);
      repeat (n_data) body.push_back(8'($urandom));
      sum = 8'h00;
      foreach (body[i]) sum += body[i];
      if (bad_sum) body.push_back(8'h00 - sum + 8'($urandom_range(1, 255)));
      else body.push_back(8'h00 - sum);
      lower = 1'($urandom_range(1));
      send_char(COLON);
      record_chars++;
      records_sent++;
      foreach (body[i]) begin
         if (cut >= 0 && i >= cut) break;
         send_hex(body[i], lower);
      end
      if (cut >= 0 && $urandom_range(1) == 1) begin
         send_char(hex_char(4'($urandom), lower));
         record_chars++;
      end
   endtask

   task automatic drain_bus();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_device_address(input logic [7:0] value);
      drain_bus();
      csr_chan.valid <= 1'b1;
      csr_chan.device_address <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic random_record();
      int         pick;
      int         cut;
      logic [7:0] count;
      logic [7:0] kind;
      bit         bad_sum;
      pick = $urandom_range(99);
      count = 8'($urandom_range(MAX_DATA));
      kind = 8'h00;
      bad_sum = 1'b0;
      cut = -1;
      if (pick < 8) bad_sum = 1'b1;
      else if (pick < 14) count = 8'($urandom_range(255, MAX_DATA + 1));
      else if (pick < 20) kind = 8'($urandom_range(255, 1));
      else if (pick < 28) cut = $urandom_range(int'(count) + 4);
      if ($urandom_range(99) < 25)
         repeat ($urandom_range(3, 1)) send_char(junk_char(1'b1));
      send_record(count, 16'($urandom), kind, bad_sum, cut);
      if ($urandom_range(99) < 4) drain_bus();
   endtask

   initial begin
      int phase_end;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.character <= 8'h00;
      csr_chan.valid <= 1'b0;
      csr_chan.device_address <= 8'h00;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_char(8'h00);
      send_char(8'hFF);
      send_char("5");
      send_record(8'd0, 16'h123C, 8'h00, 1'b0, -1);
      send_record(8'd8, 16'hABCD, 8'h00, 1'b0, -1);
      send_record(8'd2, 16'h0000, 8'h01, 1'b0, -1);
      set_device_address(8'h00);
      send_record(8'd8, 16'h00FC, 8'h00, 1'b0, -1);
      send_record(8'd3, 16'hFFFF, 8'h00, 1'b1, -1);
      set_device_address(8'hFF);
      send_record(8'd9, 16'h0010, 8'h00, 1'b0, -1);
      send_record(8'd0, 16'h0000, 8'hFF, 1'b0, -1);
      send_record(8'd5, 16'h2040, 8'h00, 1'b0, 3);

      noise_pct = 8;
      for (int p = 0; p < 3; p++) begin
         set_device_address(8'($urandom));
         calm = (p == 1);
         phase_end = chars_sent + (TOTAL_CHARS - chars_sent) / (3 - p);
         while (chars_sent < phase_end) random_record();
      end
      calm = 1'b0;

      drain_bus();
      repeat (32) @(posedge clock);
      $display("Run covered %0d records, %0d characters (%0d in records), %0d bus results checked.",
               records_sent, chars_sent, record_chars, results_seen);
      $display("Device addresses 0x00, 0xFF and random; bad sums, overlong, end and cut records.");
      if (error_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
